// ===== rtl/core/bfmc_pkg.sv =====
// shared constants and types of the box filter mip chain
package bfmc_pkg;

	localparam int MAX_WIDTH_LOG2 = 12;
	localparam int MAX_LEVELS     = 10;
	localparam int STORE_DEPTH    = 1 << MAX_WIDTH_LOG2;
	localparam int ADDR_W         = MAX_WIDTH_LOG2;
	localparam int CNT_W          = MAX_WIDTH_LOG2;
	localparam int POS_W          = MAX_WIDTH_LOG2 - 1;
	localparam int LV_W           = 4;
	localparam int LOG_W          = 4;
	localparam int CH_W           = 8;
	localparam int PIX_W          = 4 * CH_W;
	localparam int PSUM_W         = 4 * (CH_W + 1);
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = 2;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS      = 2'd2;

	localparam logic [LOG_W-1:0] RST_WIDTH_LOG2  = 4'd8;
	localparam logic [LOG_W-1:0] RST_HEIGHT_LOG2 = 4'd8;
	localparam logic [LOG_W-1:0] RST_LEVELS      = 4'd6;

	typedef struct packed {
		logic             clr;
		logic [LOG_W-1:0] wl;
		logic [LOG_W-1:0] hl;
		logic [LV_W-1:0]  eff;
	} ctl_t;

	typedef struct packed {
		logic [LV_W-1:0]  level;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [PIX_W-1:0] pix;
	} res_t;

endpackage

// ===== rtl/core/bfmc_if.sv =====
// channel interfaces: config writes, base pixels, produced mip pixels
interface bfmc_cfg_if;
	import bfmc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LOG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface bfmc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bfmc_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  level;
	logic [10:0] col;
	logic [10:0] row;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [7:0]  alpha_out;
	logic        last_of_run;
	modport source (output valid, level, col, row, red_out, green_out, blue_out,
		alpha_out, last_of_run, input ready);
	modport sink   (input valid, level, col, row, red_out, green_out, blue_out,
		alpha_out, last_of_run, output ready);
endinterface

// ===== rtl/core/bfmc_front.sv =====
// front end: config registers, level clamp and pixel queue
module bfmc_front
	import bfmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	bfmc_cfg_if.sink          cfg,
	bfmc_pix_if.sink          pixel,
	output ctl_t              ctl,
	output logic              q_valid,
	input  logic              q_ready,
	output logic [PIX_W-1:0]  q_pix
);

	logic [LOG_W-1:0]  width_log2_q;
	logic [LOG_W-1:0]  height_log2_q;
	logic [LOG_W-1:0]  levels_q;
	logic [LOG_W-1:0]  wl;
	logic [LOG_W-1:0]  hl;
	logic [LOG_W-1:0]  eff;
	logic              cfg_hit;
	logic [PIX_W-1:0]  queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign cfg.ready = 1'b1;
	assign cfg_hit   = cfg.valid && (cfg.index == REG_WIDTH_LOG2 ||
		cfg.index == REG_HEIGHT_LOG2 || cfg.index == REG_LEVELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= RST_WIDTH_LOG2;
			height_log2_q <= RST_HEIGHT_LOG2;
			levels_q      <= RST_LEVELS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WIDTH_LOG2:  width_log2_q  <= cfg.data;
				REG_HEIGHT_LOG2: height_log2_q <= cfg.data;
				REG_LEVELS:      levels_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wl  = (width_log2_q > LOG_W'(MAX_WIDTH_LOG2)) ? LOG_W'(MAX_WIDTH_LOG2) : width_log2_q;
		hl  = (height_log2_q > LOG_W'(MAX_WIDTH_LOG2)) ? LOG_W'(MAX_WIDTH_LOG2) : height_log2_q;
		eff = levels_q;
		if (eff > wl) eff = wl;
		if (eff > hl) eff = hl;
		if (eff > LOG_W'(MAX_LEVELS)) eff = LOG_W'(MAX_LEVELS);
	end

	assign ctl.clr = cfg_hit;
	assign ctl.wl  = wl;
	assign ctl.hl  = hl;
	assign ctl.eff = LV_W'(eff);

	// pixel queue
	assign pixel.ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push        = pixel.valid && pixel.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_valid && q_ready;
	assign q_pix       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/bfmc_back.sv =====
// back end: per-level walk, pair sum line store, result register
module bfmc_back
	import bfmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic              q_valid,
	output logic              q_ready,
	input  logic [PIX_W-1:0]  q_pix,
	bfmc_res_if.source        result
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LEVEL = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;

	logic [1:0]          st_q;
	logic [LV_W-1:0]     lv_q;
	logic [PIX_W-1:0]    px_q;
	logic [PSUM_W-1:0]   pair_q;
	logic [CNT_W-1:0]    col_q;
	logic [CNT_W-1:0]    row_q;
	logic [CNT_W-1:0]    col_cnt_q [MAX_LEVELS+1];
	logic [CNT_W-1:0]    row_cnt_q [MAX_LEVELS+1];
	logic [PIX_W-1:0]    held_q [MAX_LEVELS+1];
	logic [PSUM_W-1:0]   store [STORE_DEPTH];
	logic [PSUM_W-1:0]   rd_data_q;
	res_t                pend_q;
	logic                pend_v_q;
	res_t                out_q;
	logic                out_last_q;
	logic                out_v_q;

	logic [CNT_W-1:0]    col;
	logic [CNT_W-1:0]    row;
	logic [CNT_W:0]      wmask;
	logic [CNT_W:0]      hmask;
	logic [CNT_W:0]      base_w;
	logic [ADDR_W-1:0]   idx;
	logic [PSUM_W-1:0]   pair;
	logic [PIX_W-1:0]    held;
	logic [PIX_W-1:0]    np;
	logic                lv_end;
	logic                out_free;
	logic                go;
	logic                produce;
	logic                wr_en;
	logic                rd_en;

	assign col    = col_cnt_q[lv_q];
	assign row    = row_cnt_q[lv_q];
	assign held   = held_q[lv_q];
	assign lv_end = (lv_q == ctl.eff);
	assign wmask  = ((CNT_W+1)'(1) << (ctl.wl - lv_q)) - (CNT_W+1)'(1);
	assign hmask  = ((CNT_W+1)'(1) << (ctl.hl - lv_q)) - (CNT_W+1)'(1);
	assign base_w = (CNT_W+1)'(1) << ctl.wl;
	assign idx    = ADDR_W'((base_w - (base_w >> lv_q)) + (CNT_W+1)'(col[CNT_W-1:1]));

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			pair[c*(CH_W+1) +: CH_W+1] = (CH_W+1)'(held[c*CH_W +: CH_W]) +
				(CH_W+1)'(px_q[c*CH_W +: CH_W]);
			np[c*CH_W +: CH_W] = CH_W'(((CH_W+2)'(rd_data_q[c*(CH_W+1) +: CH_W+1]) +
				(CH_W+2)'(pair_q[c*(CH_W+1) +: CH_W+1])) >> 2);
		end
	end

	assign out_free = !out_v_q || result.ready;
	assign go       = (st_q == S_LEVEL) && (!pend_v_q || out_free);
	assign produce  = col[0] && row[0];
	assign wr_en    = go && !lv_end && col[0] && !row[0];
	assign rd_en    = go && !lv_end && produce;
	assign q_ready  = (st_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) store[idx] <= pair;
		if (rd_en) rd_data_q <= store[idx];
	end

	always_ff @(posedge clk) begin
		if (go && !lv_end) begin
			if (!col[0]) held_q[lv_q] <= px_q;
			pair_q <= pair;
			col_q  <= col;
			row_q  <= row;
		end
		if (st_q == S_IDLE) px_q <= q_pix;
		else if (st_q == S_READ) begin
			px_q   <= np;
			pend_q <= '{level: lv_q + 1'b1, col: col_q[CNT_W-1:1], row: row_q[CNT_W-1:1], pix: np};
		end
		if (go && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= lv_end || !produce;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			lv_q     <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			for (int l = 0; l <= MAX_LEVELS; l++) begin
				col_cnt_q[l] <= '0;
				row_cnt_q[l] <= '0;
			end
		end else begin
			if (go && pend_v_q) out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;

			if (ctl.clr) begin
				for (int l = 0; l <= MAX_LEVELS; l++) begin
					col_cnt_q[l] <= '0;
					row_cnt_q[l] <= '0;
				end
			end else if (go && !lv_end) begin
				if (col == wmask[CNT_W-1:0]) begin
					col_cnt_q[lv_q] <= '0;
					row_cnt_q[lv_q] <= (row == hmask[CNT_W-1:0]) ? '0 : row + 1'b1;
				end else begin
					col_cnt_q[lv_q] <= col + 1'b1;
				end
			end

			unique case (st_q)
				S_IDLE: begin
					lv_q <= '0;
					if (q_valid && ctl.eff != '0) st_q <= S_LEVEL;
				end
				S_LEVEL: begin
					if (go) begin
						pend_v_q <= 1'b0;
						st_q     <= (!lv_end && produce) ? S_READ : S_IDLE;
					end
				end
				S_READ: begin
					pend_v_q <= 1'b1;
					lv_q     <= lv_q + 1'b1;
					st_q     <= S_LEVEL;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid       = out_v_q;
	assign result.level       = out_q.level;
	assign result.col         = out_q.col;
	assign result.row         = out_q.row;
	assign result.red_out     = out_q.pix[0*CH_W +: CH_W];
	assign result.green_out   = out_q.pix[1*CH_W +: CH_W];
	assign result.blue_out    = out_q.pix[2*CH_W +: CH_W];
	assign result.alpha_out   = out_q.pix[3*CH_W +: CH_W];
	assign result.last_of_run = out_last_q;

endmodule

// ===== rtl/core/box_filter_mip_chain_top.sv =====
// top level of the streaming 2x2 box filter mip chain generator
//
// pixel: base-level RGBA8 pixels in raster order, valid/ready
// result: produced mip pixels with level, col, row and averaged channels,
//   in level order; last_of_run marks the final one caused by a base pixel
// cfg: register writes (width_log2, height_log2, levels_to_make); any write
//   to a listed register restarts the frame counters
// a four-entry queue sits between the pixel port and the level walker, so
//   input keeps flowing while the walker or the result port is stalled
// each base pixel is dequeued in S_IDLE and then walks the levels in S_LEVEL;
//   a level that emits a pixel also passes through S_READ (line store read),
//   and the walker takes no new pixel until it is back in S_IDLE
// results pass through a single output register; while result.ready is low
//   the walker holds at its next emit and the queue fills, then pixel.ready
//   drops
// after arst_n the registers hold 8, 8 and 6 and all counters are zero; the
//   line store needs no clearing
module box_filter_mip_chain_top
	import bfmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bfmc_cfg_if.sink    cfg,
	bfmc_pix_if.sink    pixel,
	bfmc_res_if.source  result
);

	ctl_t             ctl;
	logic             q_valid;
	logic             q_ready;
	logic [PIX_W-1:0] q_pix;

	bfmc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pixel   (pixel),
		.ctl     (ctl),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_pix   (q_pix)
	);

	bfmc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_pix   (q_pix),
		.result  (result)
	);

endmodule
